// ----- sv/uer_pkg.sv -----
// ============================================================================
// uer_pkg
// Shared types and constants of the ultrasonic echo ranger.
// ============================================================================
package uer_pkg;

	// configuration register indexes
	localparam logic [1:0] REG_TRIG_TICKS  = 2'd0;
	localparam logic [1:0] REG_TMO_TICKS   = 2'd1;
	localparam logic [1:0] REG_OFFSET      = 2'd2;
	localparam logic [1:0] REG_TICKS_UNIT  = 2'd3;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 24;
	localparam int TRIG_W     = 16;
	localparam int TMO_W      = 24;
	localparam int OFS_W      = 16;
	localparam int DIV_W      = 16;
	localparam int DIST_W     = 16;
	localparam int LED_W      = 4;

	// reset values of the configuration registers
	localparam logic [TRIG_W-1:0] TRIG_RST = 16'd10;
	localparam logic [TMO_W-1:0]  TMO_RST  = 24'd100000;
	localparam logic [OFS_W-1:0]  OFS_RST  = 16'd200;
	localparam logic [DIV_W-1:0]  DIV_RST  = 16'd834;

	localparam logic [TMO_W-1:0]  TMO_MAX  = 24'hFFFFFF;
	localparam logic [DIST_W-1:0] DIST_MAX = 16'hFFFF;

	// distance band limits and LED codes
	localparam logic [DIST_W-1:0] BAND_2  = 16'd2;
	localparam logic [DIST_W-1:0] BAND_5  = 16'd5;
	localparam logic [DIST_W-1:0] BAND_10 = 16'd10;
	localparam logic [DIST_W-1:0] BAND_15 = 16'd15;

	localparam logic [LED_W-1:0] LED_NEAR  = 4'b0001;
	localparam logic [LED_W-1:0] LED_MID   = 4'b0010;
	localparam logic [LED_W-1:0] LED_FAR   = 4'b0100;
	localparam logic [LED_W-1:0] LED_OUTER = 4'b1000;

	typedef enum logic [2:0] {
		PH_TRIG = 3'b001,
		PH_WAIT = 3'b010,
		PH_HIGH = 3'b100
	} phase_t;

	typedef enum logic [2:0] {
		BK_IDLE = 3'b001,
		BK_DIV  = 3'b010,
		BK_EMIT = 3'b100
	} back_state_t;

	// per-tick control flags passed from front to back
	typedef struct packed {
		logic trig;
		logic done;
		logic tmo;
	} ctl_t;

endpackage

// ----- sv/uer_front.sv -----
// ============================================================================
// uer_front
// Tick sequencer: trigger, echo wait and echo width count for each tick.
// ============================================================================
module uer_front #(
	parameter int COUNT_WIDTH = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            accept,
	input  logic                            echo_level,
	input  logic [uer_pkg::TRIG_W-1:0]      trigger_ticks,
	input  logic [uer_pkg::TMO_W-1:0]       timeout_ticks,
	input  logic [uer_pkg::OFS_W-1:0]       offset_ticks,
	output uer_pkg::ctl_t                   rec_ctl,
	output logic [COUNT_WIDTH-1:0]          rec_width
);
	import uer_pkg::*;

	localparam int OW = (COUNT_WIDTH > OFS_W) ? COUNT_WIDTH : OFS_W;

	phase_t                   phase_q, phase_d;
	logic [TRIG_W-1:0]        phase_cnt_q, phase_cnt_d, phase_inc, trig_len;
	logic [TMO_W-1:0]         tmo_cnt_q, tmo_cnt_d, tmo_inc;
	logic [COUNT_WIDTH-1:0]   pulse_q, pulse_d, pulse_inc;
	logic [OW-1:0]            pulse_ext, ofs_ext, width_ext;
	logic                     expired;

	assign trig_len  = (trigger_ticks == '0) ? TRIG_W'(1) : trigger_ticks;
	assign phase_inc = phase_cnt_q + TRIG_W'(1);
	assign tmo_inc   = (tmo_cnt_q < TMO_MAX) ? tmo_cnt_q + TMO_W'(1) : tmo_cnt_q;
	assign expired   = tmo_inc > timeout_ticks;
	assign pulse_inc = (pulse_q != '1) ? pulse_q + COUNT_WIDTH'(1) : pulse_q;

	// clamp the corrected width at zero
	assign pulse_ext = OW'(pulse_q);
	assign ofs_ext   = OW'(offset_ticks);
	assign width_ext = (pulse_ext > ofs_ext) ? pulse_ext - ofs_ext : '0;
	assign rec_width = COUNT_WIDTH'(width_ext);

	always_comb begin
		phase_d     = phase_q;
		phase_cnt_d = phase_cnt_q;
		tmo_cnt_d   = tmo_cnt_q;
		pulse_d     = pulse_q;
		rec_ctl     = '0;
		unique case (phase_q)
			PH_WAIT: begin
				tmo_cnt_d = tmo_inc;
				if (echo_level) begin
					phase_d = PH_HIGH;
					pulse_d = COUNT_WIDTH'(1);
				end
				if (expired) begin
					rec_ctl.tmo = 1'b1;
					phase_d     = PH_TRIG;
					phase_cnt_d = '0;
				end
			end
			PH_HIGH: begin
				if (echo_level) begin
					pulse_d   = pulse_inc;
					tmo_cnt_d = tmo_inc;
					if (expired) begin
						rec_ctl.tmo = 1'b1;
						phase_d     = PH_TRIG;
						phase_cnt_d = '0;
					end
				end else begin
					rec_ctl.done = 1'b1;
					phase_d      = PH_TRIG;
					phase_cnt_d  = '0;
				end
			end
			default: begin
				rec_ctl.trig = 1'b1;
				if (phase_inc >= trig_len) begin
					phase_d     = PH_WAIT;
					phase_cnt_d = '0;
					tmo_cnt_d   = '0;
				end else begin
					phase_d     = PH_TRIG;
					phase_cnt_d = phase_inc;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_TRIG;
			phase_cnt_q <= '0;
			tmo_cnt_q   <= '0;
			pulse_q     <= '0;
		end else if (accept) begin
			phase_q     <= phase_d;
			phase_cnt_q <= phase_cnt_d;
			tmo_cnt_q   <= tmo_cnt_d;
			pulse_q     <= pulse_d;
		end
	end

endmodule

// ----- sv/uer_queue.sv -----
// ============================================================================
// uer_queue
// Short FIFO of tick records between the sequencer and the divider side.
// ============================================================================
module uer_queue #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr_en,
	input  uer_pkg::ctl_t      wr_ctl,
	input  logic [WIDTH-1:0]   wr_width,
	output logic               full,
	input  logic               rd_en,
	output logic               empty,
	output uer_pkg::ctl_t      rd_ctl,
	output logic [WIDTH-1:0]   rd_width
);
	import uer_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	ctl_t              ctl_mem_q [DEPTH];
	logic [WIDTH-1:0]  width_mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              do_wr, do_rd;

	assign full     = count_q == CNT_W'(DEPTH);
	assign empty    = count_q == '0;
	assign do_wr    = wr_en && !full;
	assign do_rd    = rd_en && !empty;
	assign rd_ctl   = ctl_mem_q[rd_ptr_q];
	assign rd_width = width_mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			ctl_mem_q[wr_ptr_q]   <= wr_ctl;
			width_mem_q[wr_ptr_q] <= wr_width;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

// ----- sv/uer_back.sv -----
// ============================================================================
// uer_back
// Result side: bit-serial divide of finished echoes, LED banding, output reg.
// ============================================================================
module uer_back #(
	parameter int COUNT_WIDTH = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          q_empty,
	input  uer_pkg::ctl_t                 q_ctl,
	input  logic [COUNT_WIDTH-1:0]        q_width,
	output logic                          q_pop,
	input  logic [uer_pkg::DIV_W-1:0]     ticks_per_unit,
	input  logic                          pop,
	output logic                          empty,
	output logic                          trig_out,
	output logic [uer_pkg::LED_W-1:0]     leds,
	output logic [uer_pkg::DIST_W-1:0]    distance,
	output logic                          done_res,
	output logic                          timed_out
);
	import uer_pkg::*;

	localparam int CNT_W = $clog2(COUNT_WIDTH);
	localparam int OW    = (COUNT_WIDTH > DIST_W) ? COUNT_WIDTH : DIST_W;

	back_state_t             state_q;
	logic [COUNT_WIDTH-1:0]  quot_q;
	logic [DIV_W-1:0]        rem_q;
	logic [CNT_W-1:0]        bit_cnt_q;
	logic                    out_valid_q, trig_q, done_q, tmo_q;
	logic [LED_W-1:0]        leds_q, leds_new;
	logic [DIST_W-1:0]       dist_q, dist_new;
	logic [DIV_W:0]          shifted;
	logic                    ge;
	logic [OW-1:0]           quot_ext;
	logic                    out_free, load_pass, load_done;

	assign out_free  = !out_valid_q || pop;
	assign load_pass = (state_q == BK_IDLE) && !q_empty && !q_ctl.done && out_free;
	assign load_done = (state_q == BK_EMIT) && out_free;
	assign q_pop     = (state_q == BK_IDLE) && !q_empty && (q_ctl.done || out_free);

	// one restoring-division step per cycle
	assign shifted = {rem_q, quot_q[COUNT_WIDTH-1]};
	assign ge      = shifted >= {1'b0, ticks_per_unit};

	assign quot_ext = OW'(quot_q);

	always_comb begin
		if (ticks_per_unit == '0 || quot_ext > OW'(DIST_MAX)) begin
			dist_new = DIST_MAX;
		end else begin
			dist_new = quot_ext[DIST_W-1:0];
		end
		priority if (dist_new > BAND_2 && dist_new < BAND_5) begin
			leds_new = LED_NEAR;
		end else if (dist_new > BAND_5 && dist_new < BAND_10) begin
			leds_new = LED_MID;
		end else if (dist_new > BAND_10 && dist_new < BAND_15) begin
			leds_new = LED_FAR;
		end else if (dist_new > BAND_15) begin
			leds_new = LED_OUTER;
		end else begin
			leds_new = leds_q;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			BK_IDLE: begin
				quot_q    <= q_width;
				rem_q     <= '0;
				bit_cnt_q <= CNT_W'(COUNT_WIDTH - 1);
			end
			BK_DIV: begin
				quot_q    <= {quot_q[COUNT_WIDTH-2:0], ge};
				rem_q     <= ge ? DIV_W'(shifted - {1'b0, ticks_per_unit}) : shifted[DIV_W-1:0];
				bit_cnt_q <= bit_cnt_q - CNT_W'(1);
			end
			default: begin
				quot_q    <= quot_q;
				rem_q     <= rem_q;
				bit_cnt_q <= bit_cnt_q;
			end
		endcase
		if (load_pass) begin
			trig_q <= q_ctl.trig;
			done_q <= 1'b0;
			tmo_q  <= q_ctl.tmo;
		end else if (load_done) begin
			trig_q <= 1'b0;
			done_q <= 1'b1;
			tmo_q  <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			out_valid_q <= 1'b0;
			leds_q      <= '0;
			dist_q      <= '0;
		end else begin
			unique case (state_q)
				BK_IDLE: begin
					if (q_pop && q_ctl.done) begin
						state_q <= BK_DIV;
					end
				end
				BK_DIV: begin
					if (bit_cnt_q == '0) begin
						state_q <= BK_EMIT;
					end
				end
				default: begin
					if (out_free) begin
						state_q <= BK_IDLE;
					end
				end
			endcase
			if (load_done) begin
				leds_q <= leds_new;
				dist_q <= dist_new;
			end
			if (load_pass || load_done) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign empty     = !out_valid_q;
	assign trig_out  = trig_q;
	assign done_res  = done_q;
	assign timed_out = tmo_q;
	assign leds      = leds_q;
	assign distance  = dist_q;

endmodule

// ----- sv/ultrasonic_echo_ranger_top.sv -----
// ============================================================================
// ultrasonic_echo_ranger_top
// Result path: an accepted tick is written to the queue, then moved to the
//   output register; a tick that ends an echo first passes the bit-serial
//   divider (BK_DIV, then BK_EMIT) on its way to the output register.
// Throughput: one tick per cycle while the queue has room; a finished echo
//   holds the result side during the divide, and the 4-entry queue takes up
//   to four more ticks meanwhile; then full stalls input until the divide ends.
// Reset: arst_n clears the sequencer, queue, divider and output register at
//   once; configuration returns to 10 / 100000 / 200 / 834.
// ============================================================================
module ultrasonic_echo_ranger_top #(
	parameter int COUNT_WIDTH = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// tick input
	input  logic                              push,
	output logic                              full,
	input  logic                              echo_level,
	// result output
	output logic                              empty,
	input  logic                              pop,
	output logic                              trig_out,
	output logic [uer_pkg::LED_W-1:0]         leds,
	output logic [uer_pkg::DIST_W-1:0]        distance,
	output logic                              done_res,
	output logic                              timed_out,
	// configuration
	input  logic                              cfg_we,
	input  logic [uer_pkg::CFG_IDX_W-1:0]     cfg_idx,
	input  logic [uer_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
	import uer_pkg::*;

	localparam int QUEUE_DEPTH = 4;

	logic [TRIG_W-1:0]       trig_ticks_q;
	logic [TMO_W-1:0]        tmo_ticks_q;
	logic [OFS_W-1:0]        ofs_ticks_q;
	logic [DIV_W-1:0]        div_ticks_q;

	logic                    accept;
	ctl_t                    rec_ctl, q_ctl;
	logic [COUNT_WIDTH-1:0]  rec_width, q_width;
	logic                    q_full, q_empty, q_pop;

	// Configuration registers. Writes must arrive only while the block is idle;
	// the block does not enforce this. Both sides read them directly.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trig_ticks_q <= TRIG_RST;
			tmo_ticks_q  <= TMO_RST;
			ofs_ticks_q  <= OFS_RST;
			div_ticks_q  <= DIV_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_TRIG_TICKS: trig_ticks_q <= cfg_wdata[TRIG_W-1:0];
				REG_TMO_TICKS:  tmo_ticks_q  <= cfg_wdata[TMO_W-1:0];
				REG_OFFSET:     ofs_ticks_q  <= cfg_wdata[OFS_W-1:0];
				REG_TICKS_UNIT: div_ticks_q  <= cfg_wdata[DIV_W-1:0];
				default:        trig_ticks_q <= trig_ticks_q;
			endcase
		end
	end

	// The front side advances one tick per accepted transaction and writes a
	// record of that tick (flags plus corrected echo width) into the queue.
	assign full   = q_full;
	assign accept = push && !q_full;

	uer_front #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.echo_level    (echo_level),
		.trigger_ticks (trig_ticks_q),
		.timeout_ticks (tmo_ticks_q),
		.offset_ticks  (ofs_ticks_q),
		.rec_ctl       (rec_ctl),
		.rec_width     (rec_width)
	);

	// Decouple the tick sequencer from the divider so triggering continues
	// while a distance is being computed.
	uer_queue #(
		.WIDTH (COUNT_WIDTH),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (accept),
		.wr_ctl   (rec_ctl),
		.wr_width (rec_width),
		.full     (q_full),
		.rd_en    (q_pop),
		.empty    (q_empty),
		.rd_ctl   (q_ctl),
		.rd_width (q_width)
	);

	// The back side forwards plain ticks straight to the output register and
	// runs the divider plus LED banding for ticks that end an echo.
	uer_back #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.q_empty        (q_empty),
		.q_ctl          (q_ctl),
		.q_width        (q_width),
		.q_pop          (q_pop),
		.ticks_per_unit (div_ticks_q),
		.pop            (pop),
		.empty          (empty),
		.trig_out       (trig_out),
		.leds           (leds),
		.distance       (distance),
		.done_res       (done_res),
		.timed_out      (timed_out)
	);

endmodule

// ----- sv/uer_checker.sv -----
// ============================================================================
// uer_checker
// Port-level checks of the echo ranger, bound to the top level.
// ============================================================================
module uer_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          empty,
	input  logic                          pop,
	input  logic                          trig_out,
	input  logic [uer_pkg::LED_W-1:0]     leds,
	input  logic                          done_res,
	input  logic                          timed_out
);

	// a transaction cannot both finish and abandon a measurement
	a_done_xor_tmo: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> !(done_res && timed_out))
		else $error("done_res and timed_out both set");

	// trigger ticks never report a measurement outcome
	a_trig_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && trig_out) |-> (!done_res && !timed_out))
		else $error("trigger tick carries done or timeout");

	// at most one LED band is lit
	a_leds_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> $onehot0(leds))
		else $error("more than one LED lit");

	// a waiting result stays until taken
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> !empty)
		else $error("result dropped without pop");

endmodule

bind ultrasonic_echo_ranger_top uer_checker u_uer_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.empty     (empty),
	.pop       (pop),
	.trig_out  (trig_out),
	.leds      (leds),
	.done_res  (done_res),
	.timed_out (timed_out)
);

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// ============================================================================
// tb_top
// Self-checking bench for ultrasonic_echo_ranger_top. Every accepted echo
// tick runs through a cycle-true predictor of the trigger, wait and high
// phases. The predictor queues the expected trigger, LED, distance, done and
// timeout flags, and each popped result is checked against the oldest entry.
// Stimulus: directed corner settings first (zero lengths, zero divisor, a
// long echo under the widest timeout), then random settings with mostly
// well-formed echo pulses and some noise. Both sides idle at random.
// ============================================================================
module tb_top;
	import uer_pkg::*;

	localparam int CNT_W       = 16;           // echo counter width of the DUT
	localparam int SETTLE      = CNT_W + 8;    // covers the bit-serial divider
	localparam int STALL_LIMIT = 5000;         // cycles with no transaction
	localparam int HOLD_CYCLES = 200;          // long receiver hold-off
	localparam int MAX_REPORTS = 10;
	localparam int RANDOM_TICKS = 380;

	typedef struct packed {
		logic              trig;
		logic [LED_W-1:0]  leds;
		logic [DIST_W-1:0] dist_units;
		logic              done;
		logic              tmo;
	} tick_result_t;

	// ------------------------------------------------------------------------
	// Ranging predictor and the queue of results it still owes
	// ------------------------------------------------------------------------
	class ranger_scoreboard;
		logic [TRIG_W-1:0] trig_len;
		logic [TMO_W-1:0]  tmo_limit;
		logic [OFS_W-1:0]  offset;
		logic [DIV_W-1:0]  per_unit;

		phase_t            phase;
		logic [15:0]       phase_count;
		logic [TMO_W-1:0]  tmo_count;
		logic [63:0]       pulse_count;
		logic [LED_W-1:0]  led_pattern;
		logic [DIST_W-1:0] last_dist;

		tick_result_t      results_due[$];
		int                mismatches;

		function new();
			trig_len    = TRIG_RST;
			tmo_limit   = TMO_RST;
			offset      = OFS_RST;
			per_unit    = DIV_RST;
			phase       = PH_TRIG;
			phase_count = '0;
			tmo_count   = '0;
			pulse_count = '0;
			led_pattern = '0;
			last_dist   = '0;
			mismatches  = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
			REG_TRIG_TICKS: trig_len  = data[TRIG_W-1:0];
			REG_TMO_TICKS:  tmo_limit = data[TMO_W-1:0];
			REG_OFFSET:     offset    = data[OFS_W-1:0];
			REG_TICKS_UNIT: per_unit  = data[DIV_W-1:0];
			endcase
		endfunction

		// saturating timeout count; true once past the limit
		function bit bump_timeout();
			if (tmo_count < TMO_MAX)
				tmo_count++;
			return tmo_count > tmo_limit;
		endfunction

		function void rearm();
			phase       = PH_TRIG;
			phase_count = '0;
		endfunction

		function void measure_distance();
			logic [63:0] width;
			logic [63:0] quot;
			width = (pulse_count > offset) ? pulse_count - offset : 64'd0;
			quot  = (per_unit == 0) ? 64'(DIST_MAX) : width / per_unit;
			if (quot > DIST_MAX)
				quot = 64'(DIST_MAX);
			last_dist = quot[DIST_W-1:0];
			// distances on a band edge leave the pattern alone
			if (last_dist > BAND_2 && last_dist < BAND_5)
				led_pattern = LED_NEAR;
			else if (last_dist > BAND_5 && last_dist < BAND_10)
				led_pattern = LED_MID;
			else if (last_dist > BAND_10 && last_dist < BAND_15)
				led_pattern = LED_FAR;
			else if (last_dist > BAND_15)
				led_pattern = LED_OUTER;
		endfunction

		function void note_tick(logic echo);
			tick_result_t r;
			logic [15:0]  len;
			r = '0;
			case (phase)
			PH_WAIT: begin
				if (echo) begin
					phase       = PH_HIGH;
					pulse_count = 64'd1;
				end
				if (bump_timeout()) begin
					r.tmo = 1'b1;
					rearm();
				end
			end
			PH_HIGH: begin
				if (echo) begin
					if (pulse_count < (64'd1 << CNT_W) - 64'd1)
						pulse_count++;
					if (bump_timeout()) begin
						r.tmo = 1'b1;
						rearm();
					end
				end else begin
					measure_distance();
					r.done = 1'b1;
					rearm();
				end
			end
			default: begin
				// a zero length still gives a one-tick pulse
				len    = (trig_len == 0) ? 16'd1 : trig_len;
				r.trig = 1'b1;
				phase_count++;
				if (phase_count >= len) begin
					phase       = PH_WAIT;
					phase_count = '0;
					tmo_count   = '0;
				end
			end
			endcase
			r.leds       = led_pattern;
			r.dist_units = last_dist;
			results_due.push_back(r);
		endfunction

		function void check_result(tick_result_t got);
			tick_result_t want;
			if (results_due.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("%0t: result with no tick pending: %s %b %b %0d %b %b",
						$time, "trig/leds/dist/done/tmo", got.trig, got.leds,
						got.dist_units, got.done, got.tmo);
				return;
			end
			want = results_due.pop_front();
			if (got.trig !== want.trig || got.leds !== want.leds ||
				got.dist_units !== want.dist_units ||
				got.done !== want.done || got.tmo !== want.tmo) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("%0t: mismatch exp trig %b leds %b dist %0d done %b tmo %b %s",
						$time, want.trig, want.leds, want.dist_units, want.done,
						want.tmo, "/");
				if (mismatches <= MAX_REPORTS)
					$display("%0t:          got trig %b leds %b dist %0d done %b tmo %b",
						$time, got.trig, got.leds, got.dist_units, got.done, got.tmo);
			end
		endfunction
	endclass

	// ------------------------------------------------------------------------
	// DUT signals; every input starts at a known value
	// ------------------------------------------------------------------------
	logic                  clk;
	logic                  arst_n     = 1'b0;
	logic                  push       = 1'b0;
	logic                  full;
	logic                  echo_level = 1'b0;
	logic                  empty;
	logic                  pop        = 1'b0;
	logic                  trig_out;
	logic [LED_W-1:0]      leds;
	logic [DIST_W-1:0]     distance;
	logic                  done_res;
	logic                  timed_out;
	logic                  cfg_we     = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_idx    = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata  = '0;

	ranger_scoreboard sb = new();

	bit tx_quiet = 1'b0;   // sender offers back to back
	bit rx_quiet = 1'b0;   // receiver pops back to back
	bit hold_req = 1'b0;   // ask the receiver for one long hold-off
	int ticks_sent = 0;

	ultrasonic_echo_ranger_top #(
		.COUNT_WIDTH(CNT_W)
	) u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.echo_level (echo_level),
		.empty      (empty),
		.pop        (pop),
		.trig_out   (trig_out),
		.leds       (leds),
		.distance   (distance),
		.done_res   (done_res),
		.timed_out  (timed_out),
		.cfg_we     (cfg_we),
		.cfg_idx    (cfg_idx),
		.cfg_wdata  (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// mostly no gap, sometimes a few cycles, rarely a long one
	function automatic int pick_gap(bit quiet);
		int r;
		if (quiet)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// ------------------------------------------------------------------------
	// Sender side: one echo tick per transaction
	// ------------------------------------------------------------------------
	task automatic send_tick(input logic echo);
		int gap;
		gap = pick_gap(tx_quiet);
		if (gap > 0) begin
			@(negedge clk);
			push <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		push       <= 1'b1;
		echo_level <= echo;
		// hold the tick until the block has room for it
		do @(posedge clk); while (full !== 1'b0);
		sb.note_tick(echo);
		ticks_sent++;
	endtask

	// low lead-in (covers the trigger and part of the wait), echo pulse, fall
	task automatic run_echo(input int lead, input int width);
		repeat (lead) send_tick(1'b0);
		repeat (width) send_tick(1'b1);
		send_tick(1'b0);
	endtask

	task automatic run_noise(input int n);
		repeat (n) send_tick(1'($urandom_range(0, 1)));
	endtask

	// drop push and wait until every owed result has been popped
	task automatic settle();
		@(negedge clk);
		push <= 1'b0;
		while (sb.results_due.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_idx   <= idx;
		cfg_wdata <= data;
		sb.set_reg(idx, data);
	endtask

	// reprogram all four registers while the block is idle
	task automatic apply_config(input int trig, input int tmo, input int ofs, input int tpu);
		settle();
		write_reg(REG_TRIG_TICKS, CFG_DATA_W'(trig));
		write_reg(REG_TMO_TICKS,  CFG_DATA_W'(tmo));
		write_reg(REG_OFFSET,     CFG_DATA_W'(ofs));
		write_reg(REG_TICKS_UNIT, CFG_DATA_W'(tpu));
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// ------------------------------------------------------------------------
	// Receiver side: pop results, check each against the predictor
	// ------------------------------------------------------------------------
	initial begin : result_side
		int stall;
		wait (arst_n === 1'b1);
		forever begin
			if (hold_req) begin
				// long hold-off so the queue fills and full backs up the sender
				hold_req = 1'b0;
				stall    = HOLD_CYCLES;
			end else begin
				stall = pick_gap(rx_quiet);
			end
			if (stall > 0) begin
				@(negedge clk);
				pop <= 1'b0;
				repeat (stall - 1) @(negedge clk);
			end
			@(negedge clk);
			pop <= 1'b1;
			do @(posedge clk); while (empty !== 1'b0);
			sb.check_result('{trig_out, leds, distance, done_res, timed_out});
		end
	end

	// ------------------------------------------------------------------------
	// Watchdog: end the run if no transaction moves for too long
	// ------------------------------------------------------------------------
	initial begin : watchdog
		int idle;
		idle = 0;
		while (idle < STALL_LIMIT) begin
			@(posedge clk);
			if ((push && !full) || (pop && !empty))
				idle = 0;
			else
				idle++;
		end
		$display("** ultrasonic_echo_ranger_top: FAILED **");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------------
	initial begin : stimulus
		int trig;
		int tmo;
		int ofs;
		int tpu;
		int sel;
		int width;
		int random_end;
		int phase_end;
		bit first;

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset settings: short echo under the offset gives distance zero
		tx_quiet = 1'b1;
		run_echo(12, 3);

		// zero trigger length and zero timeout: timeouts right after the pulse
		tx_quiet = 1'b0;
		apply_config(0, 0, 0, 1);
		run_echo(2, 2);

		// zero divisor saturates the distance
		apply_config(1, 1000, 0, 0);
		run_echo(3, 4);

		// widest timeout and a long echo while the receiver holds off
		apply_config(5, 16777215, 0, 1);
		tx_quiet = 1'b1;
		rx_quiet = 1'b1;
		hold_req = 1'b1;
		run_echo(6, 100);

		// largest offset and divisor, then back to random settings
		apply_config(3, 500, 65535, 65535);
		run_echo(4, 20);

		first      = 1'b1;
		random_end = ticks_sent + RANDOM_TICKS;
		while (ticks_sent < random_end) begin
			sel  = $urandom_range(0, 9);
			trig = (sel == 0) ? 0 : $urandom_range(1, 6);
			tmo  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 40) : $urandom_range(200, 5000);
			ofs  = (sel == 1) ? 65535 : $urandom_range(0, 8);
			tpu  = (sel == 2) ? 0 : (sel == 3) ? 65535 : $urandom_range(1, 2);
			apply_config(trig, tmo, ofs, tpu);
			tx_quiet = ($urandom_range(0, 3) == 0);
			rx_quiet = ($urandom_range(0, 3) == 0);
			if (first) begin
				hold_req = 1'b1;
				first    = 1'b0;
			end
			phase_end = ticks_sent + $urandom_range(40, 70);
			while (ticks_sent < phase_end) begin
				if ($urandom_range(0, 4) == 0) begin
					run_noise($urandom_range(1, 8));
				end else begin
					// aim the echo width at distances around the LED bands
					if (ofs > 100 || tpu > 100)
						width = $urandom_range(1, 40);
					else
						width = ofs + ((tpu == 0) ? 1 : tpu) * $urandom_range(0, 22)
							+ $urandom_range(0, 1);
					run_echo($urandom_range(0, trig + 4), width);
				end
			end
		end

		settle();
		if (sb.mismatches == 0)
			$display("** ultrasonic_echo_ranger_top: PASSED **");
		else
			$display("** ultrasonic_echo_ranger_top: FAILED **");
		$finish;
	end

endmodule
